@@ design/sha1_message_digest_macros.svh @@
// ----------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Shorthand for the clocked, reset-gated properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SHA1MD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Constants, types and helpers shared by the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_CHAIN  = 5;
  localparam int unsigned NUM_BLOCK  = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [7:0] SHA1_PAD    = 8'h80;
  localparam logic [5:0] SHA1_LEN_AT = 6'd56;

  localparam logic [WORD_W-1:0] SHA1_IV [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef logic [NUM_CHAIN-1:0][WORD_W-1:0] chain_t;

  // Command from the sequencer to the compression unit
  typedef struct packed {
    logic              push;   // shift word into the block window
    logic [WORD_W-1:0] word;
    logic              start;  // begin 80 rounds on the window
    logic              init;   // reload initial chaining values
  } cmd_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [1:0] sel);
    logic [WORD_W-1:0] k;
    unique case (sel)
      2'd0:    k = 32'h5a827999;
      2'd1:    k = 32'h6ed9eba1;
      2'd2:    k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

@@ design/sha1md_core.sv @@
// ----------------------------------------------------------------------------
// sha1md_core
// Iterative SHA-1 compression: one round per cycle over a 16-word window.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_core
  import sha1md_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   cmd,
  output logic        done,
  output chain_t      chain
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  cstate_t           state;
  logic [6:0]        rnd;
  logic [WORD_W-1:0] a, b, c, d, e;
  // Window: win[k] holds W[t+k] at round t; also the load shift line
  logic [WORD_W-1:0] win [NUM_BLOCK];

  logic [1:0]        sel;
  logic [WORD_W-1:0] f, tmp, w_new;
  logic              shift_en;
  logic [WORD_W-1:0] shift_in;

  always_comb begin
    if (rnd < 7'd20)      sel = 2'd0;
    else if (rnd < 7'd40) sel = 2'd1;
    else if (rnd < 7'd60) sel = 2'd2;
    else                  sel = 2'd3;

    unique case (sel)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase

    w_new = rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);
    tmp   = rotl(a, 5) + f + e + round_k(sel) + win[0];

    shift_en = (state == C_ROUND) || (state == C_IDLE && cmd.push);
    shift_in = (state == C_ROUND) ? w_new : cmd.word;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < NUM_BLOCK - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[NUM_BLOCK-1] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain[i] <= SHA1_IV[i];
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (cmd.init) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
              chain[i] <= SHA1_IV[i];
            end
          end
          if (cmd.start) begin
            a     <= chain[0];
            b     <= chain[1];
            c     <= chain[2];
            d     <= chain[3];
            e     <= chain[4];
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          e   <= d;
          d   <= c;
          c   <= rotl(b, 30);
          b   <= a;
          a   <= tmp;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(NUM_ROUNDS - 1)) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          done     <= 1'b1;
          state    <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream: byte packing, padding sequencer and digest
// output around an iterative one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                     Transfer when
//  s_axis    in   tdata = data_byte, tuser = has_byte,        tvalid & tready
//                 tlast = is_last
//  m_axis    out  tdata = digest_word, tuser = word_index,    tvalid & tready
//                 tlast = last_word
//
//  A byte that does not complete a 64-byte block leaves tready high for the next.
//  A byte that completes a block is transferred, then tready stays low through
//  the compression (80 rounds, final add, done pulse in the compression unit).
//  A last item: 1 to 16 marker and padding words, then a compression; if
//  the length does not fit, 16 more padding words and a second compression
//  follow. Then five output transfers.
//  Reset (rst, synchronous) loads the initial chaining values and clears the
//  byte position and bit length. A stalled m_axis holds the digest word and
//  keeps s_axis tready low until the fifth word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // is_last
  // digest stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {S_IDLE, S_COMP, S_MARK, S_FILL, S_OUT} state_t;

  state_t            state;
  state_t            ret;        // where to go once compression finishes
  logic [5:0]        pos;        // bytes held in the current block
  logic [63:0]       bit_len;
  logic [WORD_W-1:0] part;       // word being assembled, unused lanes zero
  logic [4:0]        wcnt;       // words in the block so far, while padding
  logic              extra;      // length does not fit: an extra block first
  logic [2:0]        out_idx;

  cmd_t              cmd;
  logic              comp_done;
  chain_t            chain;

  logic              in_xfer, out_xfer;
  logic [WORD_W-1:0] byte_word;  // part with the incoming byte placed
  logic [WORD_W-1:0] mark_word;  // part with the 0x80 marker placed

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = chain[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == 3'(NUM_CHAIN - 1));

  // big-endian lane placement; lane 0 starts a fresh word
  always_comb begin
    unique case (pos[1:0])
      2'd0: begin
        byte_word = {s_axis_tdata, 24'h0};
        mark_word = {SHA1_PAD, 24'h0};
      end
      2'd1: begin
        byte_word = {part[31:24], s_axis_tdata, 16'h0};
        mark_word = {part[31:24], SHA1_PAD, 16'h0};
      end
      2'd2: begin
        byte_word = {part[31:16], s_axis_tdata, 8'h0};
        mark_word = {part[31:16], SHA1_PAD, 8'h0};
      end
      default: begin
        byte_word = {part[31:8], s_axis_tdata};
        mark_word = {part[31:8], SHA1_PAD};
      end
    endcase
  end

  // commands to the compression unit
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && s_axis_tuser && pos[1:0] == 2'd3) begin
          cmd.push = 1'b1;
          cmd.word = byte_word;
        end
        cmd.start = in_xfer && s_axis_tuser && (pos == 6'd63);
      end
      S_MARK: begin
        cmd.push = 1'b1;
        cmd.word = mark_word;
      end
      S_FILL: begin
        if (wcnt == 5'(NUM_BLOCK)) begin
          cmd.start = 1'b1;
        end else begin
          cmd.push = 1'b1;
          // words 14 and 15 carry the length, except in the extra block
          if (wcnt < 5'd14 || extra) cmd.word = '0;
          else if (wcnt == 5'd14)    cmd.word = bit_len[63:32];
          else                       cmd.word = bit_len[31:0];
        end
      end
      S_OUT:   cmd.init = out_xfer && m_axis_tlast;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      pos     <= '0;
      bit_len <= '0;
      wcnt    <= '0;
      extra   <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser) begin
              part    <= byte_word;
              pos     <= pos + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
            if (s_axis_tuser && pos == 6'd63) begin
              ret   <= s_axis_tlast ? S_MARK : S_IDLE;
              state <= S_COMP;
            end else if (s_axis_tlast) begin
              state <= S_MARK;
            end
          end
        end
        S_COMP: begin
          if (comp_done) state <= ret;
        end
        S_MARK: begin
          wcnt  <= {1'b0, pos[5:2]} + 5'd1;
          extra <= (pos >= SHA1_LEN_AT);
          state <= S_FILL;
        end
        S_FILL: begin
          if (wcnt == 5'(NUM_BLOCK)) begin
            wcnt  <= '0;
            extra <= 1'b0;
            ret   <= extra ? S_FILL : S_OUT;
            state <= S_COMP;
          end else begin
            wcnt <= wcnt + 5'd1;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (m_axis_tlast) begin
              out_idx <= '0;
              pos     <= '0;
              bit_len <= '0;
              state   <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha1md_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .done  (comp_done),
    .chain (chain)
  );

endmodule

`default_nettype wire

@@ design/sha1md_checker.sv @@
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks on the SHA-1 digest block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_message_digest_macros.svh"

module sha1md_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic in_last_xfer, out_mid_xfer;

  assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_mid_xfer = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

  // input is never taken while a digest is on offer
  `SHA1MD_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input ready during digest output")
  // tlast marks exactly the fifth word, and the index stays in range
  `SHA1MD_ASSERT_NOW(a_last_index, m_axis_tvalid, (m_axis_tlast == (m_axis_tuser == 3'd4)) && (m_axis_tuser <= 3'd4), "bad digest word index or tlast")
  // digest words follow each other in order without a gap
  `SHA1MD_ASSERT_NEXT(a_word_order, out_mid_xfer, m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)), "digest word out of order")
  // after a last item the block is busy padding and compressing
  `SHA1MD_ASSERT_NEXT(a_busy_after_last, in_last_xfer, !s_axis_tready, "input ready right after a last item")

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
